[rtl/ile_pkg.sv]
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and codes for the indexed list engine: command and status
// codes, request and response words, and the per-cell control bundle.
// ----------------------------------------------------------------------------
package ile_pkg;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_SET    = 3'd2,
    CMD_GET    = 3'd3,
    CMD_CLEAR  = 3'd4
  } ile_cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } ile_status_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  position;
    logic [31:0] write_data;
  } ile_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_data;
    logic [4:0]  entry_count;
  } ile_rsp_t;

  // Broadcast to every cell; each flag is already qualified by the range checks.
  typedef struct packed {
    logic ins;
    logic rem;
    logic set;
    logic get;
  } ile_ctrl_t;

endpackage

[rtl/ile_cell.sv]
// ----------------------------------------------------------------------------
// ile_cell
// One list slot. Takes its left neighbour on insert, its right neighbour on
// remove, loads the write data when addressed, and folds its entry into the
// read chain on a get.
// ----------------------------------------------------------------------------
module ile_cell #(
  parameter int INDEX      = 0,
  parameter int IW         = 5,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  ile_pkg::ile_ctrl_t    ctrl,
  input  logic [IW-1:0]         pos,
  input  logic [DATA_WIDTH-1:0] wd,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic [DATA_WIDTH-1:0] rd_in,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] rd_out
);
  import ile_pkg::*;

  localparam logic [IW-1:0] IDX = IW'(INDEX);

  logic hit;
  assign hit = (pos == IDX);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (IDX > pos) begin
        data <= left_data;
      end else if (hit) begin
        data <= wd;
      end
    end else if (ctrl.rem) begin
      // close the gap from the right
      if (IDX >= pos) begin
        data <= right_data;
      end
    end else if (ctrl.set && hit) begin
      data <= wd;
    end
  end

  assign rd_out = rd_in | ((ctrl.get && hit) ? data : '0);

endmodule

[rtl/indexed_list_engine_top.sv]
// ----------------------------------------------------------------------------
// indexed_list_engine_top
// Ordered list of up to CAPACITY entries held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready/req) carries one command word:
//   insert, remove, set or get at an index, or clear. Response channel
//   (rsp_valid/rsp_ready/rsp) returns one word per request with status,
//   read data (gets only) and the entry count after the command.
//   The response is registered at the edge that accepts the request.
//   Throughput is one request per cycle while the receiver keeps
//   rsp_ready high; every cell shifts or loads in the same cycle.
//   A get reads through an OR chain running along the cells.
//   While a response waits, req_ready follows rsp_ready, so a stalled
//   receiver holds the request side but loses nothing.
//   Reset empties the list (count zero) and drops any pending response;
//   entry contents are not cleared and are never seen before written.
// ----------------------------------------------------------------------------
module indexed_list_engine_top #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  ile_pkg::ile_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output ile_pkg::ile_rsp_t rsp
);
  import ile_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > 5) ? CW : 5;

  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [IW-1:0]         pos;
  logic [IW-1:0]         cnt;
  logic [DATA_WIDTH-1:0] wd;
  logic                  accept;
  logic                  full;
  ile_ctrl_t             ctrl;
  logic [1:0]            status_next;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_chain  [CAPACITY+1];

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign pos       = IW'(req.position);
  assign cnt       = IW'(count);
  assign wd        = DATA_WIDTH'(req.write_data);
  assign full      = (count == CW'(CAPACITY));

  always_comb begin
    ctrl        = '0;
    status_next = ST_OK;
    count_next  = count;
    unique case (req.cmd)
      CMD_INSERT: begin
        if (pos > cnt) begin
          status_next = ST_RANGE;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.ins   = accept;
          count_next = count + CW'(1);
        end
      end
      CMD_REMOVE: begin
        if (pos >= cnt) begin
          status_next = ST_RANGE;
        end else begin
          ctrl.rem   = accept;
          count_next = count - CW'(1);
        end
      end
      CMD_SET: begin
        if (pos >= cnt) status_next = ST_RANGE;
        else ctrl.set = accept;
      end
      CMD_GET: begin
        if (pos >= cnt) status_next = ST_RANGE;
        else ctrl.get = 1'b1;
      end
      CMD_CLEAR: begin
        count_next = '0;
      end
      default: begin
        status_next = ST_RANGE;
      end
    endcase
  end

  assign rd_chain[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    ile_cell #(
      .INDEX      (i),
      .IW         (IW),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (pos),
      .wd         (wd),
      .left_data  (left_d),
      .right_data (right_d),
      .rd_in      (rd_chain[i]),
      .data       (cell_data[i]),
      .rd_out     (rd_chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status      <= status_next;
      rsp.read_data   <= 32'(rd_chain[CAPACITY]);
      rsp.entry_count <= 5'(IW'(count_next));
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_rsp: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("accepted word gave no response");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    accept && req.cmd == CMD_CLEAR |=> rsp.entry_count == 5'd0 && count == '0)
    else $error("clear left entries behind");

  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.read_data == '0)
    else $error("read data on a failed command");

endmodule
